>>> hw/rtl/hbe_pkg.sv
// Shared types and constants of the Hill block encryption engine.
`default_nettype none

package hbe_pkg;

  localparam int unsigned SYM_W      = 5;  // symbol and key entry width
  localparam int unsigned IDX_W      = 4;  // row, column and fill counters (dimension up to 16)
  localparam int unsigned DIM_W      = 4;  // block_dimension register width
  localparam int unsigned APB_ADDR_W = 3;  // one 32-bit register at byte address 0
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [DIM_W-1:0] DIM_RESET     = 4'd2;
  localparam logic             REG_BLOCK_DIM = 1'b0;  // register index, paddr[2]

  localparam logic OP_KEY_WRITE = 1'b0;
  localparam logic OP_SYMBOL    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC,
    ST_RED_Q,
    ST_RED_R,
    ST_OUT
  } hbe_state_e;

  typedef struct packed {
    logic             key_wr;    // store key_value at (key_row, key_col)
    logic             buf_wr;    // store symbol at fill position
    logic             acc_clr;   // start a new row sum
    logic             ram_rd;    // read key entry (row, col)
    logic             mac_en;    // add key entry * buffered symbol
    logic             red_q_en;  // register reduction quotient
    logic             red_r_en;  // register reduced result into output word
    logic             last;      // output word closes the block
    logic [IDX_W-1:0] fill;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } hbe_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/hill_block_encrypt.sv
// Top level of the Hill block encryption engine with its APB register.
`default_nettype none

// Hill cipher engine, mod ALPHABET. Each input word is either a key write
// (op 0: key_value into entry key_row, key_col of the key store, ignored when
// the row or column is not below MAX_DIM) or a symbol (op 1). Symbols collect
// into a block of n = block_dimension (clamped to 2..MAX_DIM). The word that
// completes a block produces n output words, out_i = sum_j k[i][j]*x_j mod
// ALPHABET, with block_last set on the final one; load the inverse key to
// decrypt. Key writes and other symbols are taken whenever the engine is idle.
// After the last symbol of a block the engine runs a single multiply-accumulate
// unit fed by the key RAM, whose read is registered: for each row, every term
// takes a key read step and a MAC step, then the modular reduction registers
// the quotient and then the reduced result into the output register, which
// holds the word until it is taken. No input word is taken while a block is
// being computed or its results are being delivered. Key entries read by a
// block must have been written first. Writing block_dimension (APB, byte
// address 0) drops a partially collected block; write it only while idle.

module hill_block_encrypt #(
  parameter int unsigned MAX_DIM  = 9,
  parameter int unsigned ALPHABET = 26
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // APB register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hbe_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [hbe_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [hbe_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready,
  // input words
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              op_i,
  input  wire logic [hbe_pkg::IDX_W-1:0]         key_row_i,
  input  wire logic [hbe_pkg::IDX_W-1:0]         key_col_i,
  input  wire logic [hbe_pkg::SYM_W-1:0]         key_value_i,
  input  wire logic [hbe_pkg::SYM_W-1:0]         symbol_i,
  // result words
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [hbe_pkg::SYM_W-1:0]         out_symbol_o,
  output logic                                   block_last_o
);
  import hbe_pkg::*;

  localparam logic [DIM_W-1:0] MAX_N = DIM_W'(MAX_DIM);

  // block_dimension register
  logic [DIM_W-1:0] dim_q, dim_d;
  logic             cfg_wr;

  assign pready = 1'b1;
  // paddr[2] selects the register; byte offset bits are ignored
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BLOCK_DIM);
  assign dim_d  = cfg_wr ? pwdata[DIM_W-1:0] : dim_q;
  assign prdata = (paddr[2] == REG_BLOCK_DIM) ? APB_DATA_W'(dim_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RESET;
    end else begin
      dim_q <= dim_d;
    end
  end

  // active dimension minus one; values outside 2..MAX_DIM are clamped
  // (upper compare in full width so a MAX_DIM past the register range never clamps)
  logic [DIM_W-1:0] n_act;
  logic [IDX_W-1:0] nm1;

  always_comb begin
    if (dim_q < DIM_W'(2)) begin
      n_act = DIM_W'(2);
    end else if (int'(dim_q) > int'(MAX_DIM)) begin
      n_act = MAX_N;
    end else begin
      n_act = dim_q;
    end
  end

  assign nm1 = IDX_W'(n_act - 1'b1);

  hbe_cmd_t cmd;

  hbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_wr_i    (cfg_wr),
    .nm1_i       (nm1),
    .cmd_o       (cmd)
  );

  hbe_dp #(
    .MAX_DIM  (MAX_DIM),
    .ALPHABET (ALPHABET)
  ) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .key_row_i    (key_row_i),
    .key_col_i    (key_col_i),
    .key_value_i  (key_value_i),
    .symbol_i     (symbol_i),
    .out_symbol_o (out_symbol_o),
    .block_last_o (block_last_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/hbe_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module hbe_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 81
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hbe_ctrl.sv
// Sequencer: symbol collection, row/column MAC loop, reduction and output handshake.
`default_nettype none

module hbe_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    op_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  input  wire logic                    cfg_wr_i,
  input  wire logic [hbe_pkg::IDX_W-1:0] nm1_i,
  output hbe_pkg::hbe_cmd_t            cmd_o
);
  import hbe_pkg::*;

  hbe_state_e       state_q, state_d;
  logic [IDX_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0] row_q, row_d;
  logic [IDX_W-1:0] col_q, col_d;

  logic sym_acc;
  assign sym_acc = (state_q == ST_IDLE) && in_valid_i && (op_i == OP_SYMBOL);

  // next state and counters
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    row_d   = row_q;
    col_d   = col_q;
    case (state_q)
      ST_IDLE: begin
        if (sym_acc) begin
          if (fill_q == nm1_i) begin
            fill_d  = '0;
            row_d   = '0;
            col_d   = '0;
            state_d = ST_READ;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      ST_READ: state_d = ST_MAC;
      ST_MAC: begin
        if (col_q == nm1_i) begin
          state_d = ST_RED_Q;
        end else begin
          col_d   = col_q + 1'b1;
          state_d = ST_READ;
        end
      end
      ST_RED_Q: state_d = ST_RED_R;
      ST_RED_R: state_d = ST_OUT;
      ST_OUT: begin
        if (out_ready_i) begin
          if (row_q == nm1_i) begin
            state_d = ST_IDLE;
          end else begin
            row_d   = row_q + 1'b1;
            col_d   = '0;
            state_d = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // a dimension write drops any partial block
    if (cfg_wr_i) begin
      fill_d = '0;
    end
  end

  // outputs
  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    cmd_o.fill    = fill_q;
    cmd_o.row     = row_q;
    cmd_o.col     = col_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.key_wr  = in_valid_i && (op_i == OP_KEY_WRITE);
        cmd_o.buf_wr  = sym_acc;
        cmd_o.acc_clr = sym_acc && (fill_q == nm1_i);
      end
      ST_READ:  cmd_o.ram_rd   = 1'b1;
      ST_MAC:   cmd_o.mac_en   = 1'b1;
      ST_RED_Q: cmd_o.red_q_en = 1'b1;
      ST_RED_R: begin
        cmd_o.red_r_en = 1'b1;
        cmd_o.last     = (row_q == nm1_i);
      end
      ST_OUT: begin
        out_valid_o   = 1'b1;
        cmd_o.acc_clr = out_ready_i && (row_q != nm1_i);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  // fill position stays inside the active block
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= nm1_i)
    else $error("fill count beyond block dimension");

  // completing a block starts row 0, column 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_acc && (fill_q == nm1_i) |=> (state_q == ST_READ) && (row_q == '0) && (col_q == '0))
    else $error("block completion did not start the MAC loop");

  // row and column counters never pass the dimension while computing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (row_q <= nm1_i) && (col_q <= nm1_i))
    else $error("row or column counter out of range");

endmodule

`default_nettype wire

>>> hw/rtl/hbe_dp.sv
// Datapath: key store, block buffer, MAC accumulator, mod reduction, output register.
`default_nettype none

module hbe_dp #(
  parameter int unsigned MAX_DIM  = 9,
  parameter int unsigned ALPHABET = 26
) (
  input  wire logic                        clk_i,
  input  wire hbe_pkg::hbe_cmd_t           cmd_i,
  input  wire logic [hbe_pkg::IDX_W-1:0]   key_row_i,
  input  wire logic [hbe_pkg::IDX_W-1:0]   key_col_i,
  input  wire logic [hbe_pkg::SYM_W-1:0]   key_value_i,
  input  wire logic [hbe_pkg::SYM_W-1:0]   symbol_i,
  output logic      [hbe_pkg::SYM_W-1:0]   out_symbol_o,
  output logic                             block_last_o
);
  import hbe_pkg::*;

  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned KA_W    = $clog2(DEPTH);
  localparam int unsigned BI_W    = $clog2(MAX_DIM);
  localparam int unsigned SYM_MAX = (1 << SYM_W) - 1;
  localparam int unsigned SUM_W   = $clog2(MAX_DIM * SYM_MAX * SYM_MAX + 1);
  // floor(2^SUM_W / ALPHABET): quotient estimate is exact or one low
  localparam int unsigned RECIP   = (1 << SUM_W) / ALPHABET;
  localparam int unsigned ALPHA_W = $clog2(ALPHABET + 1);
  localparam int unsigned RES_W   = (ALPHA_W + 1 > SYM_W) ? ALPHA_W + 1 : SYM_W;

  logic            key_we;
  logic [KA_W-1:0] key_waddr, key_raddr;
  logic [SYM_W-1:0] key_rdata;

  assign key_we    = cmd_i.key_wr && (int'(key_row_i) < MAX_DIM) && (int'(key_col_i) < MAX_DIM);
  assign key_waddr = KA_W'(int'(key_row_i) * MAX_DIM + int'(key_col_i));
  assign key_raddr = KA_W'(int'(cmd_i.row) * MAX_DIM + int'(cmd_i.col));

  hbe_ram #(
    .WIDTH (SYM_W),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_value_i),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // block buffer
  logic [SYM_W-1:0] blk_q [MAX_DIM];

  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_wr) begin
      blk_q[cmd_i.fill[BI_W-1:0]] <= symbol_i;
    end
  end

  // multiply-accumulate, one term per MAC step
  logic [2*SYM_W-1:0] prod;
  logic [SUM_W-1:0]   acc_q;

  assign prod = key_rdata * blk_q[cmd_i.col[BI_W-1:0]];

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.mac_en) begin
      acc_q <= acc_q + SUM_W'(prod);
    end
  end

  // reduction: quotient by reciprocal, then subtract and one correction
  logic [2*SUM_W-1:0] qprod;
  logic [SUM_W-1:0]   q_q;
  logic [SUM_W-1:0]   rem_full;
  logic [RES_W-1:0]   rem, res;

  assign qprod    = acc_q * SUM_W'(RECIP);
  assign rem_full = acc_q - q_q * SUM_W'(ALPHABET);
  assign rem      = rem_full[RES_W-1:0];
  assign res      = (rem >= RES_W'(ALPHABET)) ? rem - RES_W'(ALPHABET) : rem;

  always_ff @(posedge clk_i) begin
    if (cmd_i.red_q_en) begin
      q_q <= qprod[2*SUM_W-1:SUM_W];
    end
    if (cmd_i.red_r_en) begin
      out_symbol_o <= res[SYM_W-1:0];
      block_last_o <= cmd_i.last;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/hill_block_encrypt_test.sv
// Self-checking testbench for the Hill block encryption engine.
`timescale 1ns / 1ps

module hill_block_encrypt_test;

  import hbe_pkg::*;

  localparam int unsigned MAX_DIM  = 9;
  localparam int unsigned ALPHABET = 26;

  // Worst block's compute time plus a margin; a partial block never produces a
  // word, so any APB write waits this long after the last word has drained.
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_DIM * MAX_DIM + 3 * MAX_DIM + 40;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam logic [APB_ADDR_W-1:0] DIM_ADDR = {REG_BLOCK_DIM, 2'b00};

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } cipher_word_t;

  logic clk_i;
  logic rst_ni;

  // APB
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // input word channel
  logic             in_valid;
  logic             in_ready_o;
  logic             op_in;
  logic [IDX_W-1:0] row_in;
  logic [IDX_W-1:0] col_in;
  logic [SYM_W-1:0] kval_in;
  logic [SYM_W-1:0] sym_in;

  // result word channel
  logic             out_valid_o;
  logic             out_ready;
  logic [SYM_W-1:0] out_symbol_o;
  logic             block_last_o;

  // Shadow of the engine: key matrix, held symbols, dimension register.
  logic [SYM_W-1:0] key_mat [MAX_DIM][MAX_DIM];
  logic [SYM_W-1:0] held_syms [MAX_DIM];
  int unsigned      syms_held;
  logic [DIM_W-1:0] dim_reg;

  cipher_word_t cipher_due [$];  // words the engine still owes us

  int unsigned err_count;
  bit          calm;          // both sides run without idling
  int unsigned hold_request;  // cycles the result side should refuse words

  hill_block_encrypt #(
    .MAX_DIM  (MAX_DIM),
    .ALPHABET (ALPHABET)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .op_i         (op_in),
    .key_row_i    (row_in),
    .key_col_i    (col_in),
    .key_value_i  (kval_in),
    .symbol_i     (sym_in),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .out_symbol_o (out_symbol_o),
    .block_last_o (block_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("hill_block_encrypt test failed");
    $finish;
  end

  // Block dimension as the engine applies it: clamped to 2..MAX_DIM.
  function automatic int unsigned active_dim();
    if (dim_reg < 2) return 2;
    if (dim_reg > MAX_DIM) return MAX_DIM;
    return 32'(dim_reg);
  endfunction

  // Update the shadow with one accepted word; queue the block's result words
  // once the final symbol of a block is in.
  task automatic advance_cipher(input logic op, input logic [IDX_W-1:0] row,
                                input logic [IDX_W-1:0] col,
                                input logic [SYM_W-1:0] kval,
                                input logic [SYM_W-1:0] sym);
    int unsigned n;
    int unsigned acc;
    int unsigned r;
    int unsigned c;
    cipher_word_t w;
    n = active_dim();
    if (op == OP_KEY_WRITE) begin
      // out-of-range rows/cols are dropped, never aliased
      if (row < MAX_DIM && col < MAX_DIM) key_mat[row][col] = kval;
    end else begin
      if (syms_held >= n) syms_held = 0;
      held_syms[syms_held] = sym;
      syms_held++;
      if (syms_held == n) begin
        for (r = 0; r < n; r++) begin
          acc = 0;
          for (c = 0; c < n; c++) acc += key_mat[r][c] * held_syms[c];
          w.sym  = SYM_W'(acc % ALPHABET);
          w.last = (r + 1 == n);
          cipher_due = {cipher_due, w};
        end
        syms_held = 0;
      end
    end
  endtask

  // Offer one word and hold it until taken; idle the channel now and then.
  task automatic send_word(input logic op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col,
                           input logic [SYM_W-1:0] kval,
                           input logic [SYM_W-1:0] sym);
    op_in    <= op;
    row_in   <= row;
    col_in   <= col;
    kval_in  <= kval;
    sym_in   <= sym;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    advance_cipher(op, row, col, kval, sym);
    if (!calm) begin
      while ($urandom_range(99) < 13) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  // Unused fields of each word carry random bits so every input bit toggles.
  task automatic send_key(input int unsigned row, input int unsigned col,
                          input int unsigned kval);
    send_word(OP_KEY_WRITE, IDX_W'(row), IDX_W'(col), SYM_W'(kval),
              SYM_W'($urandom_range(31)));
  endtask

  task automatic send_symbol(input int unsigned sym);
    send_word(OP_SYMBOL, IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)),
              SYM_W'($urandom_range(31)), SYM_W'(sym));
  endtask

  // Stop offering words and wait until every owed word has come back.
  task automatic wait_results;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (cipher_due.size() != 0) @(posedge clk_i);
  endtask

  // Register writes only with the engine idle: drained, then settled.
  task automatic set_dimension(input int unsigned value);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIM_ADDR;
    pwdata  <= APB_DATA_W'(value & 4'hF);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    dim_reg   = DIM_W'(value);
    syms_held = 0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_block;
    repeat (active_dim()) send_symbol($urandom_range(31));
  endtask

  // ---- tests ----------------------------------------------------------------

  // Fill the whole store first so no block ever reads an unwritten entry.
  task automatic test_key_load;
    for (int unsigned r = 0; r < MAX_DIM; r++)
      for (int unsigned c = 0; c < MAX_DIM; c++)
        send_key(r, c, $urandom_range(31));
  endtask

  // Reset dimension (2), field extremes, ignored key writes, raw values above 25.
  task automatic test_directed_extremes;
    send_key(15, 15, 31);  // both indexes out of range
    send_key(9, 3, 7);     // row just past the store
    send_key(2, 9, 5);     // column past the store; must not land on row 3
    send_key(0, 15, 11);
    send_key(8, 8, 17);    // stored, outside the 2x2 corner
    send_key(0, 0, 31);
    send_key(0, 1, 0);
    send_key(1, 0, 25);
    send_key(1, 1, 26);
    send_symbol(0);
    send_symbol(0);
    send_symbol(31);
    send_symbol(31);
    send_symbol(25);
    send_symbol(26);
    send_symbol(1);
    send_symbol(30);
  endtask

  // Clamp on both ends of the register, plus a few in-range sizes.
  task automatic test_dimension_sweep;
    int unsigned dims [7];
    dims = '{0, 1, 9, 15, 10, 2, 3};
    foreach (dims[i]) begin
      set_dimension(dims[i]);
      send_block();
    end
  endtask

  // A register write drops the half-collected block, even with the same value.
  task automatic test_partial_drop;
    set_dimension(5);
    repeat (3) send_symbol($urandom_range(31));
    set_dimension(5);
    send_block();
    repeat (2) send_symbol($urandom_range(31));
    set_dimension(4);
    send_block();
  endtask

  // Sender goes quiet mid-block until all words are back; the partial block
  // must survive the pause.
  task automatic test_drain_pause;
    set_dimension(3);
    repeat (7) send_symbol($urandom_range(31));
    wait_results();
    repeat (2) send_symbol($urandom_range(31));
  endtask

  // Long refusal on the result side while words keep coming back to back:
  // the engine must fill up and hold its input.
  task automatic test_output_backpressure;
    set_dimension(3);
    calm         = 1'b1;
    hold_request = 400;
    repeat (30) send_symbol($urandom_range(31));
    wait_results();
    calm = 1'b0;
  endtask

  // Mostly symbol streams with key rewrites sprinkled in, over several sizes.
  task automatic test_random_traffic;
    int unsigned row;
    int unsigned col;
    for (int p = 0; p < 5; p++) begin
      set_dimension((p == 0) ? 9 : $urandom_range(15));
      calm = (p == 2);  // one phase at full rate on both sides
      for (int k = 0; k < 12; k++) begin
        if ($urandom_range(99) < 20) begin
          row = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(MAX_DIM - 1);
          col = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(MAX_DIM - 1);
          send_key(row, col, $urandom_range(31));
        end else begin
          send_symbol($urandom_range(31));
        end
      end
      calm = 1'b0;
    end
  endtask

  // ---- result side ----------------------------------------------------------

  // Ready driver: random idling, always ready when calm, or a counted hold when a test asks for one.
  initial begin : result_sink
    int unsigned hold;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold         = hold_request;
        hold_request = 0;
        out_ready <= 1'b0;
        for (int unsigned c = 1; c < hold; c++) @(posedge clk_i);
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 13);
      end
    end
  end

  // Every taken result word against the oldest owed one.
  always @(posedge clk_i) begin : result_check
    cipher_word_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (cipher_due.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("%0t: word with none owed: out_symbol %0d block_last %0b",
                   $realtime, out_symbol_o, block_last_o);
      end else begin
        want = cipher_due.pop_front();
        if (out_symbol_o !== want.sym || block_last_o !== want.last) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("%0t: mismatch: out_symbol exp %0d got %0d, block_last exp %0b got %0b",
                     $realtime, want.sym, out_symbol_o, want.last, block_last_o);
        end
      end
    end
  end

  // ---- sequence -------------------------------------------------------------

  initial begin : run
    err_count    = 0;
    calm         = 1'b0;
    hold_request = 0;
    syms_held    = 0;
    dim_reg      = DIM_RESET;
    rst_ni   <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    op_in    <= OP_KEY_WRITE;
    row_in   <= '0;
    col_in   <= '0;
    kval_in  <= '0;
    sym_in   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_key_load();
    test_directed_extremes();
    test_dimension_sweep();
    test_partial_drop();
    test_drain_pause();
    test_output_backpressure();
    test_random_traffic();

    // drain, then give a stray word time to show up
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0 && cipher_due.size() == 0) begin
      $display("hill_block_encrypt test passed");
    end else begin
      $display("hill_block_encrypt test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/hbe_pkg.sv
hw/rtl/hbe_ram.sv
hw/rtl/hbe_ctrl.sv
hw/rtl/hbe_dp.sv
hw/rtl/hill_block_encrypt.sv
tb/sv/hill_block_encrypt_test.sv
